// ----- rtl/tdpc_pkg.sv -----
// Shared types and constants for the trial-division prime counter.
package tdpc_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    // Candidates at or below this limit are counted through the base
    localparam int unsigned SMALL_LIMIT   = 10;
    localparam int unsigned FIRST_DIVISOR = 3;
    localparam int unsigned DIVISOR_STEP  = 2;
    localparam logic [3:0]  BASE_RESET    = 4'd4;

    // Register map
    localparam int unsigned ADDR_W         = 3;
    localparam logic        REG_COUNT_BASE = 1'b0;
    localparam int unsigned BASE_W         = 4;

    // Result word layout
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned OUT_W   = 72;

endpackage

// ----- rtl/trial_division_prime_counter.sv -----
// Top level of the trial-division prime counter: sequencer, shared subtractor and totals.
//
// Each input word carries one candidate; the block answers with one result word that says
// whether the candidate is a prime above ten and gives the running prime count and the latest
// prime. The work depends on the data: small or even candidates skip the search; others
// first find the floor square root, then make one remainder pass per odd trial divisor
// from 3 up to that root, stopping at the first divisor that leaves no remainder. All of
// that work runs one bit per cycle through a single compare-and-subtract unit shared by
// the root and the remainder steps, and s_tready is low until the sequencer returns to
// idle. A finished result waits in the output register, and the next word is taken
// meanwhile. The count_base register (address 0) is loaded into the count on reset and on
// a word with clear_totals set; the count saturates at all ones.
module trial_division_prime_counter #(
    parameter int CANDIDATE_BITS = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // s_tdata: candidate, clear_totals (low bit up)
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [((CANDIDATE_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    // m_tdata: is_prime, prime_count, last_prime (low bit up)
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [tdpc_pkg::OUT_W-1:0]                 m_tdata,
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [tdpc_pkg::ADDR_W-1:0]                paddr,
    input  logic [31:0]                                pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);
    import tdpc_pkg::*;

    localparam int CB   = CANDIDATE_BITS;
    localparam int HB   = (CB + 1) / 2;     // root width
    localparam int SQ_W = 2 * HB;           // candidate padded to whole digit pairs
    localparam int UW   = HB + 2;           // shared unit width
    localparam int DW   = HB + 1;           // divisor width, holds root + 2
    localparam int SW   = $clog2(CB);       // step counter width

    state_t              state_reg, state_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [CB-1:0]       cand_reg, cand_next;
    logic [SQ_W-1:0]     sh_reg, sh_next;
    logic [UW-1:0]       rem_reg, rem_next;
    logic [HB-1:0]       root_reg, root_next;
    logic [DW-1:0]       div_reg, div_next;
    logic [SW-1:0]       step_reg, step_next;
    logic                prime_reg, prime_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [31:0]         latest_reg, latest_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_prime_reg, out_prime_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [31:0]         out_latest_reg, out_latest_next;

    logic                in_fire, cfg_write, out_free;
    logic [CB-1:0]       in_cand;
    logic                in_clear, in_skip;
    logic [UW-1:0]       unit_a, unit_b;
    logic [UW:0]         unit_diff;
    logic                unit_ge;
    logic                step_last;

    assign in_cand   = s_tdata[CB-1:0];
    assign in_clear  = s_tdata[CB];
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || m_tready;
    assign in_skip   = (in_cand <= CB'(SMALL_LIMIT)) || !in_cand[0];
    assign step_last = (step_reg == '0);

    // Shared compare-and-subtract unit
    always_comb begin
        if (state_reg == ST_ROOT) begin
            unit_a = {rem_reg[UW-3:0], sh_reg[SQ_W-1:SQ_W-2]};
            unit_b = {root_reg, 2'b01};
        end else begin
            unit_a = {rem_reg[UW-2:0], sh_reg[SQ_W-1]};
            unit_b = UW'(div_reg);
        end
        unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
        unit_ge   = !unit_diff[UW];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = in_skip ? ST_DONE : ST_ROOT;
            ST_ROOT:  if (step_last) state_next = ST_CHECK;
            ST_CHECK: state_next = (div_reg > {1'b0, root_reg}) ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (step_last) begin
                    state_next = (unit_ge ? unit_diff[UW-1:0] : unit_a) == '0 ? ST_DONE
                                                                           : ST_CHECK;
                end
            end
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = out_valid_reg;
        m_tdata  = {7'b0, out_latest_reg, out_count_reg, out_prime_reg};
        pready   = 1'b1;
        prdata   = (paddr[2] == REG_COUNT_BASE) ? 32'(base_reg) : '0;
    end

    // Datapath
    always_comb begin
        base_next       = base_reg;
        cand_next       = cand_reg;
        sh_next         = sh_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        prime_next      = prime_reg;
        count_next      = count_reg;
        latest_next     = latest_reg;
        out_valid_next  = out_valid_reg;
        out_prime_next  = out_prime_reg;
        out_count_next  = out_count_reg;
        out_latest_next = out_latest_reg;

        if (cfg_write && paddr[2] == REG_COUNT_BASE) base_next = pwdata[BASE_W-1:0];
        if (m_tvalid && m_tready) out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cand_next  = in_cand;
                    sh_next    = SQ_W'(in_cand);
                    rem_next   = '0;
                    root_next  = '0;
                    div_next   = DW'(FIRST_DIVISOR);
                    step_next  = SW'(HB - 1);
                    prime_next = 1'b0;
                    if (in_clear) begin
                        count_next  = COUNT_W'(base_reg);
                        latest_next = '0;
                    end
                end
            end
            ST_ROOT: begin
                // one root digit per cycle
                rem_next  = unit_ge ? unit_diff[UW-1:0] : unit_a;
                root_next = {root_reg[HB-2:0], unit_ge};
                sh_next   = sh_reg << 2;
                step_next = step_reg - 1'b1;
            end
            ST_CHECK: begin
                // divisors past the root: prime; otherwise start a remainder pass
                if (div_reg > {1'b0, root_reg}) begin
                    prime_next = 1'b1;
                end else begin
                    rem_next  = '0;
                    sh_next   = SQ_W'(cand_reg) << (SQ_W - CB);
                    step_next = SW'(CB - 1);
                end
            end
            ST_DIV: begin
                // one remainder bit per cycle, then advance to the next odd divisor
                rem_next  = unit_ge ? unit_diff[UW-1:0] : unit_a;
                sh_next   = sh_reg << 1;
                step_next = step_reg - 1'b1;
                if (step_last) div_next = div_reg + DW'(DIVISOR_STEP);
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_reg;
                    out_count_next = count_reg;
                    out_latest_next = latest_reg;
                    if (prime_reg) begin
                        if (count_reg != '1) begin
                            count_next     = count_reg + 1'b1;
                            out_count_next = count_reg + 1'b1;
                        end
                        latest_next     = 32'(cand_reg);
                        out_latest_next = 32'(cand_reg);
                    end
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            base_reg      <= BASE_RESET;
            count_reg     <= COUNT_W'(BASE_RESET);
            latest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
            latest_reg    <= latest_next;
            out_valid_reg <= out_valid_next;
        end
        cand_reg       <= cand_next;
        sh_reg         <= sh_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        div_reg        <= div_next;
        step_reg       <= step_next;
        prime_reg      <= prime_next;
        out_prime_reg  <= out_prime_next;
        out_count_reg  <= out_count_next;
        out_latest_reg <= out_latest_next;
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input accepted twice in a row");

    a_div_within_root: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_reg <= {1'b0, root_reg})
        else $error("trial divisor beyond root");

    a_prime_is_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[33])
        else $error("even value reported prime");

    a_prime_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[32:1] != '0)
        else $error("prime reported with zero count");

endmodule

// ----- verif/trial_division_prime_counter_tb.sv -----
// Testbench for the trial-division prime counter: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps

module trial_division_prime_counter_tb;
    import tdpc_pkg::*;

    localparam int          CAND_W      = 32;
    localparam int          S_W         = ((CAND_W + 8) / 8) * 8;
    localparam int unsigned UNUSED_REG  = 1;
    localparam int          STALL_LIMIT = 300000;
    localparam int          HOLD_CYCLES = 400;

    localparam logic [ADDR_W-1:0] BASE_ADDR   = ADDR_W'(4 * REG_COUNT_BASE);
    localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4 * UNUSED_REG);

    // Predicts the result word of each accepted candidate and checks what comes out
    class prime_tally_board;
        typedef struct packed {
            logic        is_prime;
            logic [31:0] count;
            logic [31:0] last;
        } tally_t;

        logic [BASE_W-1:0] base_val;
        logic [31:0]       running_count;
        logic [31:0]       newest_prime;
        tally_t            pending_tallies[$];
        int                errors;

        function new();
            base_val      = BASE_RESET;
            running_count = 32'(BASE_RESET);
            newest_prime  = '0;
            errors        = 0;
        endfunction

        function void set_base(logic [BASE_W-1:0] v);
            base_val = v;
        endfunction

        function int pending();
            return pending_tallies.size();
        endfunction

        // Only odd candidates above the small limit can pass the divisor scan
        static function bit survives_division(logic [31:0] n);
            longint unsigned d;
            if (n <= SMALL_LIMIT || !n[0])
                return 1'b0;
            for (d = FIRST_DIVISOR; d * d <= longint'(n); d += DIVISOR_STEP) begin
                if (longint'(n) % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_candidate(logic [31:0] cand, logic clr);
            tally_t t;
            if (clr) begin
                running_count = 32'(base_val);
                newest_prime  = '0;
            end
            t.is_prime = survives_division(cand);
            if (t.is_prime) begin
                if (running_count != '1)
                    running_count++;
                newest_prime = cand;
            end
            t.count = running_count;
            t.last  = newest_prime;
            pending_tallies.push_back(t);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got 0x%08h want 0x%08h", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] word);
            tally_t t;
            if (pending_tallies.size() == 0) begin
                report("unexpected result word", word[31:0], '0);
                return;
            end
            t = pending_tallies.pop_front();
            if (word[0] !== t.is_prime)
                report("is_prime", 32'(word[0]), 32'(t.is_prime));
            if (word[32:1] !== t.count)
                report("prime_count", word[32:1], t.count);
            if (word[64:33] !== t.last)
                report("last_prime", word[64:33], t.last);
        endtask
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // s_tdata: candidate, clear_totals (low bit up)
    logic [S_W-1:0]     s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // m_tdata: is_prime, prime_count, last_prime (low bit up)
    logic [OUT_W-1:0]   m_tdata;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    prime_tally_board   board = new();
    bit                 idle_on  = 1'b1;
    bit                 hold_req = 1'b0;
    int                 quiet_cycles = 0;

    trial_division_prime_counter #(.CANDIDATE_BITS(CAND_W)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("trial_division_prime_counter_tb: FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!aresetn) begin
                m_tready = 1'b0;
            end else if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // One APB transfer: setup then access; returns read data
    task apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                    input logic [31:0] data, output logic [31:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        if (wr && addr == BASE_ADDR)
            board.set_base(data[BASE_W-1:0]);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write count_base and read it back
    task program_base(input logic [BASE_W-1:0] v);
        logic [31:0] rd;
        apb_access(1'b1, BASE_ADDR, {$urandom_range(0, 1) ? $urandom : 32'h0} & ~32'hF | v, rd);
        apb_access(1'b0, BASE_ADDR, '0, rd);
        if (rd !== 32'(v))
            board.report("count_base readback", rd, 32'(v));
    endtask

    // Offer one word and hold it until the block takes it
    task send_word(input logic [31:0] cand, input logic clr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = S_W'({clr, cand});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_candidate(cand, clr);
        @(negedge aclk);
    endtask

    // Wait until every predicted result has come back
    task drain;
        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly small odd numbers; some medium ones, some full-width noise with cheap factors
    task send_random(input int n);
        logic [31:0] v;
        int          pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                v = $urandom & ~32'h1;
            end else if (pick < 11) begin
                v = $urandom;
                v = v - v % 3;
            end else if (pick < 15) begin
                v = $urandom_range(4096, 65535) | 32'h1;
            end else if (pick < 22) begin
                v = $urandom_range(0, 4095);
            end else begin
                v = $urandom_range(0, 4095) | 32'h1;
            end
            send_word(v, $urandom_range(0, 15) == 0);
        end
        s_tvalid = 1'b0;
    endtask

    initial begin
        logic [32:0] directed[] = '{
            {1'b0, 32'd0}, {1'b0, 32'd1}, {1'b0, 32'd2}, {1'b0, 32'd7},
            {1'b0, 32'd10}, {1'b0, 32'd11}, {1'b0, 32'd12}, {1'b0, 32'd13},
            {1'b0, 32'd15}, {1'b0, 32'd25}, {1'b0, 32'd49}, {1'b0, 32'd121},
            {1'b1, 32'd17}, {1'b0, 32'hFFFF_FFFF}, {1'b0, 32'hFFFF_FFFE},
            {1'b0, 32'h8000_0000}, {1'b0, 32'h5555_5555}, {1'b0, 32'd65521},
            {1'b1, 32'd9}, {1'b0, 32'd1048573}, {1'b1, 32'hAAAA_AAAB},
            {1'b0, 32'd16777213}, {1'b0, 32'd4095}
        };
        logic [31:0] rd;

        // Hold reset, then release
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed candidates at the reset base
        foreach (directed[i])
            send_word(directed[i][31:0], directed[i][32]);
        s_tvalid = 1'b0;
        drain();

        // Highest base, with a long receiver hold-off at the start
        program_base(4'hF);
        send_word(32'd3, 1'b1);
        hold_req = 1'b1;
        send_random(150);
        drain();

        // Lowest base
        program_base(4'h0);
        send_word(32'd31, 1'b1);
        send_random(150);
        drain();

        // A write to an unmapped register must leave the base alone
        program_base(4'($urandom_range(1, 14)));
        apb_access(1'b1, UNUSED_ADDR, $urandom, rd);
        send_word(32'd0, 1'b1);
        send_random(150);
        drain();

        // Last stretch without any idling
        program_base(4'($urandom_range(0, 15)));
        idle_on = 1'b0;
        send_word(32'd101, 1'b1);
        send_random(125);
        drain();
        repeat (50) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("trial_division_prime_counter_tb: PASS");
        end else begin
            $display("trial_division_prime_counter_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- trial_division_prime_counter.f -----
rtl/tdpc_pkg.sv
rtl/trial_division_prime_counter.sv
verif/trial_division_prime_counter_tb.sv
